FILE: rtl/umcr_pkg.sv
// Shared types and constants for the motor command receiver.
package umcr_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COUNT_W  = PERIOD_W + 1;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd16;

  localparam logic [BYTE_W-1:0] CMD_FORWARD  = 8'h70;
  localparam logic [BYTE_W-1:0] CMD_BACKWARD = 8'h6F;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] fwd;
    logic [BYTE_W-1:0] bwd;
    logic              updated;
  } duty_t;

endpackage

FILE: rtl/umcr_channels.sv
// Line sample and result channel interfaces.
interface umcr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface umcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_forward;
  logic [7:0] duty_backward;
  logic       byte_done;
  logic [7:0] rx_byte;
  logic       duty_updated;

  modport source (output valid, output duty_forward, output duty_backward,
                  output byte_done, output rx_byte, output duty_updated,
                  input ready);
  modport sink (input valid, input duty_forward, input duty_backward,
                input byte_done, input rx_byte, input duty_updated,
                output ready);
endinterface

FILE: rtl/umcr_cmd_parser.sv
// Command parser: 'p'/'o' letter followed by a duty byte.
module umcr_cmd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  umcr_pkg::rx_beat_t rx_beat,
  output umcr_pkg::duty_t    duty_nxt
);
  import umcr_pkg::*;

  typedef enum logic [1:0] {
    CS_LETTER     = 2'd0,
    CS_FWD_VALUE  = 2'd1,
    CS_BACK_VALUE = 2'd2
  } cmd_state_t;

  cmd_state_t        state_r, state_nxt;
  logic [BYTE_W-1:0] fwd_r, bwd_r;

  always_comb begin
    state_nxt        = state_r;
    duty_nxt.fwd     = fwd_r;
    duty_nxt.bwd     = bwd_r;
    duty_nxt.updated = 1'b0;
    if (rx_beat.valid) begin
      case (state_r)
        CS_FWD_VALUE: begin
          duty_nxt.fwd     = rx_beat.data;
          duty_nxt.bwd     = '0;
          duty_nxt.updated = 1'b1;
          state_nxt        = (rx_beat.data == CMD_BACKWARD) ? CS_BACK_VALUE : CS_LETTER;
        end
        CS_BACK_VALUE: begin
          duty_nxt.bwd     = rx_beat.data;
          duty_nxt.fwd     = '0;
          duty_nxt.updated = 1'b1;
          state_nxt        = CS_LETTER;
        end
        default: begin
          if (rx_beat.data == CMD_FORWARD) begin
            state_nxt = CS_FWD_VALUE;
          end else if (rx_beat.data == CMD_BACKWARD) begin
            state_nxt = CS_BACK_VALUE;
          end else begin
            state_nxt = CS_LETTER;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_LETTER;
      fwd_r   <= '0;
      bwd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fwd_r   <= duty_nxt.fwd;
      bwd_r   <= duty_nxt.bwd;
    end
  end

endmodule

FILE: rtl/uart_motor_command_receiver.sv
// Top level: 8N1 serial receiver feeding the motor duty command parser.
//
// Usage: in_ch carries one sampled level of the serial receive line per
// beat; every accepted beat is one receiver tick and yields exactly one
// beat on out_ch with the forward and backward duties after that tick,
// a byte-complete flag with the received byte (zero otherwise) and a flag
// that is high when a command value changed the duties.
// cfg_wr_en/cfg_wr_data write bit_period, the number of ticks per serial
// bit; write it only while no result is outstanding.
// Latency: the result of a line beat is presented on the cycle after it is
// accepted, from the output register.
// Throughput: one line beat per cycle unless a waiting result stalls;
// receive counters and parser update in one registered step per beat.
// Stall: while out_ch.ready is low a waiting result holds and in_ch.ready
// drops; the tick counters advance only on accepted beats, so stalls do
// not disturb bit timing measured in beats.
// Reset: rst_n (synchronous, active low) returns the receiver to idle,
// clears both duties and the parser, empties the output register and sets
// bit_period to 16.
module uart_motor_command_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  umcr_in_if.sink                       in_ch,
  umcr_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [umcr_pkg::PERIOD_W-1:0] cfg_wr_data
);
  import umcr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_GUARD = 2'd2
  } rx_phase_t;

  rx_phase_t          phase_r, phase_nxt;
  logic [COUNT_W-1:0] tick_r, tick_nxt;
  logic [2:0]         bit_idx_r, bit_idx_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [PERIOD_W-1:0] period_r;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_fwd_r, out_bwd_r, out_byte_r;
  logic               out_done_r, out_upd_r;

  logic               in_acc;
  logic [COUNT_W-1:0] long_wait, target, tick_inc;
  rx_beat_t           rx_beat;
  duty_t              duty_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign long_wait = {1'b0, period_r} + {2'b00, period_r[PERIOD_W-1:1]};
  assign target    = (bit_idx_r == 3'd0) ? long_wait : {1'b0, period_r};
  assign tick_inc  = tick_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    rx_beat      = '0;
    case (phase_r)
      PH_DATA: begin
        tick_nxt = tick_inc;
        if (tick_inc >= target) begin
          tick_nxt = '0;
          shift_nxt[bit_idx_r] = shift_r[bit_idx_r] | in_ch.line_level;
          if (bit_idx_r == 3'd7) begin
            phase_nxt   = PH_GUARD;
            bit_idx_nxt = '0;
          end else begin
            bit_idx_nxt = bit_idx_r + 1'b1;
          end
        end
      end
      PH_GUARD: begin
        tick_nxt = tick_inc;
        if (tick_inc >= long_wait) begin
          tick_nxt     = '0;
          phase_nxt    = PH_IDLE;
          rx_beat.valid = 1'b1;
          rx_beat.data  = shift_r;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!in_ch.line_level) begin
          phase_nxt   = PH_DATA;
          tick_nxt    = '0;
          bit_idx_nxt = '0;
          shift_nxt   = '0;
        end
      end
    endcase
    rx_beat.valid = rx_beat.valid && in_acc;
  end

  umcr_cmd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .rx_beat  (rx_beat),
    .duty_nxt (duty_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      period_r    <= BIT_PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_fwd_r  <= duty_nxt.fwd;
      out_bwd_r  <= duty_nxt.bwd;
      out_done_r <= rx_beat.valid;
      out_byte_r <= rx_beat.valid ? rx_beat.data : '0;
      out_upd_r  <= duty_nxt.updated;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_forward  = out_fwd_r;
  assign out_ch.duty_backward = out_bwd_r;
  assign out_ch.byte_done     = out_done_r;
  assign out_ch.rx_byte       = out_byte_r;
  assign out_ch.duty_updated  = out_upd_r;

  a_upd_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.duty_updated |-> out_ch.byte_done)
    else $error("duty update without a completed byte");

  a_one_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.duty_updated |->
      (out_ch.duty_forward == '0) || (out_ch.duty_backward == '0))
    else $error("both duties non-zero after a command");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_done |-> out_ch.rx_byte == '0)
    else $error("byte shown without byte_done");

  a_guard_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_GUARD |-> bit_idx_r == 3'd0)
    else $error("bit index not cleared in guard phase");

  a_done_from_guard: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && rx_beat.valid |=> phase_r == PH_IDLE && out_ch.byte_done)
    else $error("byte completion did not return receiver to idle");

endmodule

FILE: bench/tb_uart_motor_command_receiver.sv
`timescale 1ns / 1ps
// Testbench for the serial motor command receiver: line beats in, duty results checked.
module tb_uart_motor_command_receiver;
  import umcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_DATA  = 2'd1,
    RX_GUARD = 2'd2
  } rx_phase_t;

  typedef enum logic [1:0] {
    CS_LETTER     = 2'd0,
    CS_FWD_VALUE  = 2'd1,
    CS_BACK_VALUE = 2'd2
  } cmd_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] fwd;
    logic [BYTE_W-1:0] bwd;
    logic              done;
    logic [BYTE_W-1:0] rx_byte;
    logic              updated;
  } motor_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [PERIOD_W-1:0] cfg_wr_data;

  umcr_in_if  line_ch ();
  umcr_out_if duty_ch ();

  uart_motor_command_receiver u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (line_ch),
    .out_ch      (duty_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [PERIOD_W-1:0] period_q;
  rx_phase_t           rx_phase_q;
  logic [COUNT_W-1:0]  tick_q;
  logic [2:0]          bit_q;
  logic [BYTE_W-1:0]   shift_q;
  cmd_state_t          cmd_q;
  logic [BYTE_W-1:0]   fwd_q;
  logic [BYTE_W-1:0]   bwd_q;

  motor_result_t expected_duties[$];
  int unsigned   mismatches;
  int unsigned   lines_sent;
  int unsigned   cycles = 0;
  int unsigned   line_gap_pct;
  int unsigned   ready_gap_pct;
  logic          hold_off;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("uart_motor_command_receiver test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    duty_ch.ready <= !hold_off && ($urandom_range(0, 99) >= ready_gap_pct);
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : check_duties
    motor_result_t want;
    if (rst_n && duty_ch.valid && duty_ch.ready) begin
      if (expected_duties.size() == 0) begin
        report_mismatch("result beat with none outstanding", 0, 1);
      end else begin
        want = expected_duties.pop_front();
        if (duty_ch.duty_forward !== want.fwd)
          report_mismatch("duty_forward", 32'(want.fwd), 32'(duty_ch.duty_forward));
        if (duty_ch.duty_backward !== want.bwd)
          report_mismatch("duty_backward", 32'(want.bwd), 32'(duty_ch.duty_backward));
        if (duty_ch.byte_done !== want.done)
          report_mismatch("byte_done", 32'(want.done), 32'(duty_ch.byte_done));
        if (duty_ch.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", 32'(want.rx_byte), 32'(duty_ch.rx_byte));
        if (duty_ch.duty_updated !== want.updated)
          report_mismatch("duty_updated", 32'(want.updated), 32'(duty_ch.duty_updated));
      end
    end
  end

  function automatic void step_receiver(input logic level);
    logic [COUNT_W-1:0] long_wait;
    logic [COUNT_W-1:0] target;
    logic               done;
    logic [BYTE_W-1:0]  got;
    logic               updated;
    long_wait = {1'b0, period_q} + {2'b00, period_q[PERIOD_W-1:1]};
    done      = 1'b0;
    got       = '0;
    updated   = 1'b0;
    case (rx_phase_q)
      RX_DATA: begin
        tick_q = tick_q + 1'b1;
        target = (bit_q == 3'd0) ? long_wait : {1'b0, period_q};
        if (tick_q >= target) begin
          tick_q = '0;
          if (level)
            shift_q[bit_q] = 1'b1;
          if (bit_q == 3'd7) begin
            rx_phase_q = RX_GUARD;
            bit_q      = 3'd0;
          end else begin
            bit_q = bit_q + 1'b1;
          end
        end
      end
      RX_GUARD: begin
        tick_q = tick_q + 1'b1;
        if (tick_q >= long_wait) begin
          tick_q     = '0;
          rx_phase_q = RX_IDLE;
          done       = 1'b1;
          got        = shift_q;
          case (cmd_q)
            CS_FWD_VALUE: begin
              fwd_q   = got;
              bwd_q   = '0;
              updated = 1'b1;
              cmd_q   = (got == CMD_BACKWARD) ? CS_BACK_VALUE : CS_LETTER;
            end
            CS_BACK_VALUE: begin
              bwd_q   = got;
              fwd_q   = '0;
              updated = 1'b1;
              cmd_q   = CS_LETTER;
            end
            default: begin
              if (got == CMD_FORWARD)
                cmd_q = CS_FWD_VALUE;
              else if (got == CMD_BACKWARD)
                cmd_q = CS_BACK_VALUE;
              else
                cmd_q = CS_LETTER;
            end
          endcase
        end
      end
      default: begin
        rx_phase_q = RX_IDLE;
        if (!level) begin
          rx_phase_q = RX_DATA;
          tick_q     = '0;
          bit_q      = 3'd0;
          shift_q    = '0;
        end
      end
    endcase
    expected_duties.push_back('{fwd: fwd_q, bwd: bwd_q, done: done, rx_byte: got,
                                updated: updated});
  endfunction

  task automatic send_line(input logic level);
    while ($urandom_range(0, 99) < line_gap_pct) begin
      line_ch.valid <= 1'b0;
      @(posedge clk);
    end
    line_ch.valid      <= 1'b1;
    line_ch.line_level <= level;
    do @(posedge clk); while (!line_ch.ready);
    step_receiver(level);
    lines_sent++;
  endtask

  task automatic send_hold(input logic level, input int unsigned beats);
    repeat (beats) send_line(level);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] value, input int unsigned extra_stop);
    int unsigned bit_len;
    bit_len = (period_q < 2) ? 1 : period_q;
    send_hold(1'b0, bit_len);
    for (int i = 0; i < BYTE_W; i++)
      send_hold(value[i], bit_len);
    send_hold(1'b1, bit_len + 1 + extra_stop);
  endtask

  task automatic wait_for_results();
    line_ch.valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_bit_period(input logic [PERIOD_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_q = value;
  endtask

  task automatic test_default_period();
    send_hold(1'b1, 4);
    send_frame(CMD_FORWARD, 0);
    write_bit_period(16'd2);
    send_frame(8'hFF, 0);
  endtask

  task automatic test_command_set();
    logic [BYTE_W-1:0] cmds [10];
    cmds = '{CMD_BACKWARD, 8'h00, CMD_FORWARD, CMD_BACKWARD, 8'h80,
             CMD_BACKWARD, CMD_FORWARD, 8'h41, CMD_FORWARD, 8'h55};
    write_bit_period(16'd2);
    foreach (cmds[i])
      send_frame(cmds[i], i % 3);
  endtask

  task automatic test_tiny_periods();
    write_bit_period(16'd1);
    send_frame(CMD_FORWARD, 0);
    send_frame(8'hAA, 1);
    write_bit_period(16'd0);
    send_frame(CMD_BACKWARD, 0);
    send_frame(8'h5A, 0);
    send_line(1'b0);
    send_hold(1'b1, 14);
  endtask

  task automatic test_period_change_mid_byte();
    write_bit_period(16'hFFFF);
    send_hold(1'b1, 2);
    send_line(1'b0);
    repeat (60) send_line(1'($urandom_range(0, 1)));
    write_bit_period(16'd3);
    send_hold(1'b1, 50);
    send_frame(CMD_FORWARD, 0);
    send_frame(8'h3C, 0);
  endtask

  task automatic test_back_pressure();
    int unsigned saved_line;
    int unsigned saved_ready;
    saved_line  = line_gap_pct;
    saved_ready = ready_gap_pct;
    write_bit_period(16'd4);
    line_gap_pct  = 0;
    ready_gap_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_frame(CMD_FORWARD, 0);
    send_frame(BYTE_W'($urandom_range(0, 255)), 0);
    send_frame(CMD_BACKWARD, 0);
    send_frame(BYTE_W'($urandom_range(0, 255)), 0);
    wait_for_results();
    send_frame(CMD_FORWARD, 1);
    send_frame(BYTE_W'($urandom_range(0, 255)), 0);
    line_gap_pct  = saved_line;
    ready_gap_pct = saved_ready;
  endtask

  task automatic test_random_traffic(input int unsigned line_pct, input int unsigned ready_pct,
                                     input int unsigned quota);
    int unsigned       stop_at;
    int unsigned       chunk_end;
    int unsigned       bit_len;
    logic [BYTE_W-1:0] value;
    line_gap_pct  = line_pct;
    ready_gap_pct = ready_pct;
    stop_at       = lines_sent + quota;
    while (lines_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       write_bit_period(PERIOD_W'($urandom_range(0, 1)));
        1:       write_bit_period(PERIOD_W'($urandom_range(6, 12)));
        default: write_bit_period(PERIOD_W'($urandom_range(2, 5)));
      endcase
      bit_len   = (period_q < 2) ? 1 : period_q;
      chunk_end = lines_sent + 50;
      while (lines_sent < chunk_end && lines_sent < stop_at) begin
        case ($urandom_range(0, 5))
          0:       value = CMD_BACKWARD;
          1:       value = CMD_FORWARD;
          2:       value = 8'h00;
          3:       value = 8'hFF;
          default: value = BYTE_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_frame($urandom_range(0, 1) ? CMD_FORWARD : CMD_BACKWARD,
                       $urandom_range(0, 3));
            send_frame(value, $urandom_range(0, 3));
          end
          6: send_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 2));
          7: begin
            repeat ($urandom_range(1, 8)) send_line(1'($urandom_range(0, 1)));
            send_hold(1'b1, 10 * bit_len + 2);
          end
          8: begin
            send_hold(1'b0, bit_len);
            repeat ($urandom_range(0, 7) * bit_len) send_line(1'($urandom_range(0, 1)));
            send_hold(1'b1, 10 * bit_len + 2);
          end
          default: send_frame(value, 0);
        endcase
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    line_ch.valid      = 1'b0;
    line_ch.line_level = 1'b1;
    hold_off           = 1'b0;
    mismatches         = 0;
    lines_sent         = 0;
    line_gap_pct       = 19;
    ready_gap_pct      = 50;
    period_q           = BIT_PERIOD_RESET;
    rx_phase_q         = RX_IDLE;
    tick_q             = '0;
    bit_q              = 3'd0;
    shift_q            = '0;
    cmd_q              = CS_LETTER;
    fwd_q              = '0;
    bwd_q              = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_period();
    test_command_set();
    test_tiny_periods();
    test_period_change_mid_byte();
    test_back_pressure();
    test_random_traffic(19, 50, 130);
    test_random_traffic(50, 19, 130);
    test_random_traffic(0, 0, 130);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("uart_motor_command_receiver test passed");
    else
      $display("uart_motor_command_receiver test failed");
    $finish;
  end

endmodule
